### hw/rtl/vertex_transform_4x4_defines.svh
// ----------------------------------------------------------------------------
// vertex_transform_4x4 assertion macros
// Concurrent checks on the clock; both forms are held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VT4_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define VT4_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define VT4_ASSERT_SAME(lbl, ante, cons, msg)
`define VT4_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg
// Types, constants and binary32 stage functions for the vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

   localparam int WORD_W     = 32;
   localparam int CSR_W      = 64;
   localparam int REG_COUNT  = 8;
   localparam int REG_IDX_W  = 3;
   localparam int SIG_W      = 58;
   localparam int ALN_W      = 56;
   localparam int MUL_STAGES = 3;
   localparam int ADD_STAGES = 4;
   localparam int STAGES     = MUL_STAGES + 3 * ADD_STAGES;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

   localparam logic [CSR_W-1:0] ONE_LO = 64'h0000_0000_3F80_0000;
   localparam logic [CSR_W-1:0] ONE_HI = 64'h3F80_0000_0000_0000;

   // unrounded value: sig * 2^scale, or a finished special result
   typedef struct packed {
      logic               sign;
      logic               spec;
      logic [31:0]        spec_val;
      logic signed [9:0]  scale;
      logic [SIG_W-1:0]   sig;
   } unr_type;

   // normalized: msb of n at the top, e is the biased exponent before rounding
   typedef struct packed {
      logic               sign;
      logic               spec;
      logic [31:0]        spec_val;
      logic signed [9:0]  e;
      logic [SIG_W-1:0]   n;
   } nrm_type;

   typedef struct packed {
      logic               sign;
      logic               sub;
      logic               spec;
      logic [31:0]        spec_val;
      logic signed [9:0]  scale;
      logic [ALN_W-1:0]   big;
      logic [ALN_W-1:0]   small_op;
   } aln_type;

   function automatic logic is_nan(logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic [CSR_W-1:0] reset_val(logic [REG_IDX_W-1:0] idx);
      logic [CSR_W-1:0] v;
      case (idx)
         REG_ROW0_COLS01: v = ONE_LO;
         REG_ROW1_COLS01: v = ONE_HI;
         REG_ROW2_COLS23: v = ONE_LO;
         REG_ROW3_COLS23: v = ONE_HI;
         default:         v = '0;
      endcase
      return v;
   endfunction

   function automatic unr_type fmul_pre(logic [31:0] a, logic [31:0] b);
      unr_type           r;
      logic              za, zb, ia, ib, s;
      logic signed [9:0] xa, xb;
      logic [23:0]       ma, mb;
      logic [47:0]       prod;
      s  = a[31] ^ b[31];
      za = (a[30:0] == 31'd0);
      zb = (b[30:0] == 31'd0);
      ia = (a[30:0] == INF_MAG);
      ib = (b[30:0] == INF_MAG);
      xa = (a[30:23] == 8'd0) ? 10'sd1 : signed'({2'b00, a[30:23]});
      xb = (b[30:23] == 8'd0) ? 10'sd1 : signed'({2'b00, b[30:23]});
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      prod = 48'(ma) * 48'(mb);
      r.sign     = s;
      r.scale    = xa + xb - 10'sd300;
      r.sig      = {10'd0, prod};
      r.spec     = 1'b1;
      r.spec_val = '0;
      if (is_nan(a) || is_nan(b)) begin
         r.spec_val = QNAN_BITS;
      end else if ((ia && zb) || (ib && za)) begin
         r.spec_val = QNAN_BITS;
      end else if (ia || ib) begin
         r.spec_val = {s, INF_MAG};
      end else if (za || zb) begin
         r.spec_val = {s, 31'd0};
      end else begin
         r.spec = 1'b0;
      end
      return r;
   endfunction

   function automatic aln_type fadd_align(logic [31:0] a, logic [31:0] b);
      aln_type          r;
      logic             ia, ib, za, zb, swap;
      logic [7:0]       xa, xb, xbig, xsml, diff;
      logic [23:0]      ma, mb, mbig, msml;
      logic [ALN_W-1:0] sm;
      ia = (a[30:0] == INF_MAG);
      ib = (b[30:0] == INF_MAG);
      za = (a[30:0] == 31'd0);
      zb = (b[30:0] == 31'd0);
      xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      swap = (xa < xb) || ((xa == xb) && (ma < mb));
      xbig = swap ? xb : xa;
      xsml = swap ? xa : xb;
      mbig = swap ? mb : ma;
      msml = swap ? ma : mb;
      diff = xbig - xsml;
      sm   = {msml, 32'd0};
      r.sign     = swap ? b[31] : a[31];
      r.sub      = a[31] ^ b[31];
      r.scale    = signed'({2'b00, xbig}) - 10'sd182;
      r.big      = {mbig, 32'd0};
      r.small_op = (sm >> diff) | ALN_W'(|(sm & ~({ALN_W{1'b1}} << diff)));
      r.spec     = 1'b1;
      r.spec_val = '0;
      if (is_nan(a) || is_nan(b)) begin
         r.spec_val = QNAN_BITS;
      end else if (ia && ib) begin
         r.spec_val = (a[31] != b[31]) ? QNAN_BITS : a;
      end else if (ia) begin
         r.spec_val = a;
      end else if (ib) begin
         r.spec_val = b;
      end else if (za && zb) begin
         r.spec_val = {a[31] & b[31], 31'd0};
      end else if (za) begin
         r.spec_val = b;
      end else if (zb) begin
         r.spec_val = a;
      end else begin
         r.spec = 1'b0;
      end
      return r;
   endfunction

   function automatic unr_type fadd_sum(aln_type x);
      unr_type      r;
      logic [56:0]  s;
      s = x.sub ? ({1'b0, x.big} - {1'b0, x.small_op}) : ({1'b0, x.big} + {1'b0, x.small_op});
      r.sign     = x.sign;
      r.scale    = x.scale;
      r.sig      = {1'b0, s};
      r.spec     = x.spec;
      r.spec_val = x.spec_val;
      // exact cancellation gives +0
      if (!x.spec && x.sub && (s == 57'd0)) begin
         r.spec     = 1'b1;
         r.spec_val = '0;
      end
      return r;
   endfunction

   function automatic nrm_type normalize(unr_type u);
      nrm_type    r;
      logic [5:0] lz;
      lz = '0;
      for (int i = 0; i < SIG_W; i++) begin
         if (u.sig[i]) lz = 6'(SIG_W - 1 - i);
      end
      r.sign     = u.sign;
      r.spec     = u.spec;
      r.spec_val = u.spec_val;
      r.n        = u.sig << lz;
      r.e        = 10'(SIG_W - 1 + 127) - signed'({4'd0, lz}) + u.scale;
      return r;
   endfunction

   function automatic logic [31:0] round_pack(nrm_type x);
      logic [5:0]       sh;
      logic [SIG_W-1:0] m;
      logic             lost, rb, st, up;
      logic [23:0]      keep;
      logic [24:0]      k25;
      logic [31:0]      bits, res;
      sh = '0;
      if (x.e < 10'sd1) begin
         sh = (x.e < -10'sd61) ? 6'd63 : 6'(10'sd1 - x.e);
      end
      m    = x.n >> sh;
      lost = |(x.n & ~({SIG_W{1'b1}} << sh));
      keep = m[SIG_W-1 -: 24];
      rb   = m[SIG_W-25];
      st   = (|m[SIG_W-26:0]) | lost;
      up   = rb & (st | keep[0]);
      k25  = {1'b0, keep} + 25'(up);
      if (x.e < 10'sd1) begin
         bits = {7'd0, k25};
      end else begin
         bits = ((32'(x.e[7:0]) - 32'd1) << 23) + 32'(k25);
      end
      if (x.spec) begin
         res = x.spec_val;
      end else if ((x.e >= 10'sd255) || (bits >= {1'b0, INF_MAG})) begin
         res = {x.sign, INF_MAG};
      end else begin
         res = {x.sign, bits[30:0]};
      end
      return res;
   endfunction

endpackage

### hw/rtl/vt4_req_if.sv
// ----------------------------------------------------------------------------
// vt4_req_if
// Vertex request channel: four binary32 components.
// ----------------------------------------------------------------------------
interface vt4_req_if;
   logic                        valid;
   logic                        ready;
   logic [vt4_pkg::WORD_W-1:0]  vec_x;
   logic [vt4_pkg::WORD_W-1:0]  vec_y;
   logic [vt4_pkg::WORD_W-1:0]  vec_z;
   logic [vt4_pkg::WORD_W-1:0]  vec_w;
   modport source (output valid, vec_x, vec_y, vec_z, vec_w, input ready);
   modport sink   (input valid, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

### hw/rtl/vt4_rsp_if.sv
// ----------------------------------------------------------------------------
// vt4_rsp_if
// Transformed vertex response channel.
// ----------------------------------------------------------------------------
interface vt4_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vt4_pkg::WORD_W-1:0]  out_x;
   logic [vt4_pkg::WORD_W-1:0]  out_y;
   logic [vt4_pkg::WORD_W-1:0]  out_z;
   logic [vt4_pkg::WORD_W-1:0]  out_w;
   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

### hw/rtl/vt4_csr_if.sv
// ----------------------------------------------------------------------------
// vt4_csr_if
// Matrix register write channel.
// ----------------------------------------------------------------------------
interface vt4_csr_if;
   logic                           valid;
   logic                           ready;
   logic [vt4_pkg::REG_IDX_W-1:0]  reg_index;
   logic [vt4_pkg::CSR_W-1:0]      wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### hw/rtl/vt4_fmul.sv
// ----------------------------------------------------------------------------
// vt4_fmul
// Three-stage binary32 multiplier: product, normalize, round.
// ----------------------------------------------------------------------------
module vt4_fmul (
   input  logic                               clock,
   input  logic [vt4_pkg::MUL_STAGES-1:0]     en,
   input  logic [vt4_pkg::WORD_W-1:0]         a,
   input  logic [vt4_pkg::WORD_W-1:0]         b,
   output logic [vt4_pkg::WORD_W-1:0]         y
);
   import vt4_pkg::*;

   unr_type     prod_ff;
   nrm_type     nrm_ff;
   logic [31:0] y_ff;

   always_ff @(posedge clock) begin
      if (en[0]) prod_ff <= fmul_pre(a, b);
      if (en[1]) nrm_ff  <= normalize(prod_ff);
      if (en[2]) y_ff    <= round_pack(nrm_ff);
   end

   assign y = y_ff;
endmodule

### hw/rtl/vt4_fadd.sv
// ----------------------------------------------------------------------------
// vt4_fadd
// Four-stage binary32 adder: align, add, normalize, round.
// ----------------------------------------------------------------------------
module vt4_fadd (
   input  logic                               clock,
   input  logic [vt4_pkg::ADD_STAGES-1:0]     en,
   input  logic [vt4_pkg::WORD_W-1:0]         a,
   input  logic [vt4_pkg::WORD_W-1:0]         b,
   output logic [vt4_pkg::WORD_W-1:0]         y
);
   import vt4_pkg::*;

   aln_type     aln_ff;
   unr_type     sum_ff;
   nrm_type     nrm_ff;
   logic [31:0] y_ff;

   always_ff @(posedge clock) begin
      if (en[0]) aln_ff <= fadd_align(a, b);
      if (en[1]) sum_ff <= fadd_sum(aln_ff);
      if (en[2]) nrm_ff <= normalize(sum_ff);
      if (en[3]) y_ff   <= round_pack(nrm_ff);
   end

   assign y = y_ff;
endmodule

### hw/rtl/vertex_transform_4x4.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4
// Row-major 4x4 binary32 matrix times homogeneous vertex, rounded per op.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_bus  in   valid/ready          vec_x, vec_y, vec_z, vec_w
//  rsp_bus  out  valid/ready          out_x, out_y, out_z, out_w
//  csr_bus  in   valid/ready (ready=1) reg_index, wr_data
//
//  One vertex per cycle while rsp_bus is not stalling; a 3-stage multiply, then
//  three 4-stage adds in series; the last adder stage is the response register.
//  Each stage holds its own valid bit and only stalls when the stage after
//  it is full and stalled, so bubbles close up under rsp back-pressure.
//  Reset empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_defines.svh"

module vertex_transform_4x4 (
   input  logic        clock,
   input  logic        reset,
   vt4_req_if.sink     req_bus,
   vt4_rsp_if.source   rsp_bus,
   vt4_csr_if.sink     csr_bus
);
   import vt4_pkg::*;

   localparam int ADD1_S = MUL_STAGES;
   localparam int ADD2_S = ADD1_S + ADD_STAGES;
   localparam int ADD3_S = ADD2_S + ADD_STAGES;
   localparam int MUL2_S = ADD2_S - MUL_STAGES;
   localparam int MUL3_S = ADD3_S - MUL_STAGES;

   logic [CSR_W-1:0]  mat_ff [REG_COUNT];
   logic [STAGES-1:0] vld_ff, vld_in, en_w;
   logic [31:0]       vz_ff [MUL2_S];
   logic [31:0]       vw_ff [MUL3_S];
   logic [31:0]       res_w [4];

   // matrix registers
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      for (int i = 0; i < REG_COUNT; i++) begin
         if (reset) begin
            mat_ff[i] <= reset_val(REG_IDX_W'(i));
         end else if (csr_bus.valid && (csr_bus.reg_index == REG_IDX_W'(i))) begin
            mat_ff[i] <= csr_bus.wr_data;
         end
      end
   end

   // stage k advances when it is empty or stage k+1 advances
   always_comb begin
      en_w[STAGES-1] = !vld_ff[STAGES-1] || rsp_bus.ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         en_w[k] = !vld_ff[k] || en_w[k+1];
      end
      vld_in[0] = en_w[0] ? req_bus.valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = en_w[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= vld_in;
   end

   // z and w wait for their later multiplies
   always_ff @(posedge clock) begin
      if (en_w[0]) begin
         vz_ff[0] <= req_bus.vec_z;
         vw_ff[0] <= req_bus.vec_w;
      end
      for (int k = 1; k < MUL2_S; k++) begin
         if (en_w[k]) vz_ff[k] <= vz_ff[k-1];
      end
      for (int k = 1; k < MUL3_S; k++) begin
         if (en_w[k]) vw_ff[k] <= vw_ff[k-1];
      end
   end

   assign req_bus.ready = en_w[0];

   for (genvar r = 0; r < 4; r++) begin : g_row
      logic [31:0] p0, p1, p2, p3, s1, s2;

      vt4_fmul u_mul0 (.clock(clock), .en(en_w[MUL_STAGES-1:0]),
                       .a(req_bus.vec_x), .b(mat_ff[2*r][31:0]), .y(p0));
      vt4_fmul u_mul1 (.clock(clock), .en(en_w[MUL_STAGES-1:0]),
                       .a(req_bus.vec_y), .b(mat_ff[2*r][63:32]), .y(p1));
      vt4_fadd u_add1 (.clock(clock), .en(en_w[ADD1_S +: ADD_STAGES]),
                       .a(p0), .b(p1), .y(s1));
      vt4_fmul u_mul2 (.clock(clock), .en(en_w[MUL2_S +: MUL_STAGES]),
                       .a(vz_ff[MUL2_S-1]), .b(mat_ff[2*r+1][31:0]), .y(p2));
      vt4_fadd u_add2 (.clock(clock), .en(en_w[ADD2_S +: ADD_STAGES]),
                       .a(s1), .b(p2), .y(s2));
      vt4_fmul u_mul3 (.clock(clock), .en(en_w[MUL3_S +: MUL_STAGES]),
                       .a(vw_ff[MUL3_S-1]), .b(mat_ff[2*r+1][63:32]), .y(p3));
      vt4_fadd u_add3 (.clock(clock), .en(en_w[ADD3_S +: ADD_STAGES]),
                       .a(s2), .b(p3), .y(res_w[r]));
   end

   assign rsp_bus.valid = vld_ff[STAGES-1];
   assign rsp_bus.out_x = res_w[0];
   assign rsp_bus.out_y = res_w[1];
   assign rsp_bus.out_z = res_w[2];
   assign rsp_bus.out_w = res_w[3];

   // request is refused only when every stage holds a vertex
   `VT4_ASSERT_SAME(a_full_when_blocked, !req_bus.ready, &vld_ff, "input blocked with a bubble")
   `VT4_ASSERT_NEXT(a_accept_lands, req_bus.valid && req_bus.ready, vld_ff[0], "accepted request lost")
   `VT4_ASSERT_NEXT(a_stall_holds, rsp_bus.valid && !rsp_bus.ready, &vld_ff[STAGES-1 -: 2] || !vld_ff[STAGES-2] && vld_ff[STAGES-1], "stalled output dropped")

endmodule
